[hw/rtl/msfl_pkg.sv]
// Package for the multi-stack shared free list.
// Item types, operation and status codes, controller states. No dependencies.
package msfl_pkg;

   localparam int DATA_W = 32;
   localparam int SID_W  = 3;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } msfl_func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } msfl_status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } msfl_state_type;

   typedef struct packed {
      logic                     func;
      logic [SID_W-1:0]         stack_id;
      logic signed [DATA_W-1:0] value;
   } msfl_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic [1:0]               status;
   } msfl_rsp_type;

   // free list commands from the controller
   typedef struct packed {
      logic alloc;     // take the head slot
      logic release_s; // return a slot as the new head
   } msfl_fl_cmd_type;

endpackage

[hw/rtl/msfl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module msfl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[hw/rtl/msfl_free.sv]
// Free list head and fresh-slot counter for the multi-stack free list.
// Depends on msfl_pkg. Slots at or above the counter are untouched and chain in order.
module msfl_free
   import msfl_pkg::*;
#(
   parameter int SLOTS = 256,
   parameter int LW    = $clog2(SLOTS + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  msfl_fl_cmd_type cmd,
   input  logic [LW-1:0]   link_rdata,
   input  logic [LW-1:0]   release_slot,
   output logic [LW-1:0]   free_head,
   output logic            head_nil
);

   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] fresh_ff, fresh_in;
   logic          fresh_hit;

   // head equal to the counter means the head slot was never used:
   // its link is implicitly the next slot (or nil past the end)
   assign fresh_hit = (head_ff == fresh_ff);

   always_comb begin
      head_in  = head_ff;
      fresh_in = fresh_ff;
      if (cmd.alloc) begin
         if (fresh_hit) begin
            head_in  = head_ff + LW'(1);
            fresh_in = fresh_ff + LW'(1);
         end else begin
            head_in = link_rdata;
         end
      end else if (cmd.release_s) begin
         head_in = release_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         fresh_ff <= '0;
      end else begin
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
      end
   end

   assign free_head = head_ff;
   assign head_nil  = (head_ff == LW'(SLOTS));

endmodule

[hw/rtl/multi_stack_shared_free_list.sv]
// Top level of the multi-stack shared free list.
// Depends on msfl_pkg, msfl_ram and msfl_free.
//
// Usage:
//   req channel: one item per operation (func push/pop, stack_id, value).
//   rsp channel: one item per request (popped_value, status), in order.
//   Both use valid/stall; an item moves when valid is high and stall low.
// Timing:
//   An accepted item reads the link and data memories in the accept cycle,
//   and the next cycle (ST_EXEC) uses the read data, writes the link
//   memory (and the data memory on a push) for a successful operation and
//   loads the response register, which drives response valid. No new item
//   is taken while an item is in ST_EXEC: req_stall is high there, so the
//   link-memory read and its write-back never overlap.
// Reset:
//   All stacks empty, free head at slot 0. No clearing pass:
//   slots never handed out are tracked by a fresh counter and chain in
//   order implicitly, so link read data is only used where it was written.
// Back-pressure:
//   A response held by rsp_stall stays in the output register; a new
//   request is still taken as long as that response leaves in the same
//   cycle, otherwise req_stall is raised.
module multi_stack_shared_free_list
   import msfl_pkg::*;
#(
   parameter int SLOTS      = 256,
   parameter int NUM_STACKS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  msfl_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output msfl_rsp_type rsp_payload
);

   localparam int AW   = $clog2(SLOTS);
   localparam int LW   = $clog2(SLOTS + 1);
   // only stacks reachable through the 3-bit id get storage
   localparam int TOPS = (NUM_STACKS < (1 << SID_W)) ? NUM_STACKS : (1 << SID_W);
   localparam int TW   = (TOPS > 1) ? $clog2(TOPS) : 1;
   localparam logic [LW-1:0] NIL = LW'(SLOTS);

   msfl_state_type state_ff, state_in;

   // captured item
   logic                     op_ff;
   logic [SID_W-1:0]         sid_ff;
   logic signed [DATA_W-1:0] val_ff;

   logic [LW-1:0] top_ff [TOPS];
   logic [LW-1:0] top_in [TOPS];

   msfl_rsp_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic req_exists, cur_exists;
   logic [LW-1:0] req_top, cur_top;
   logic [LW-1:0] free_head;
   logic          head_nil;
   logic          push_ok, pop_ok, exec;

   logic [LW-1:0]     link_rdata, link_wdata, link_raddr_full, slot;
   logic [AW-1:0]     link_raddr;
   logic [DATA_W-1:0] data_rdata;
   logic              link_we, data_we;
   msfl_fl_cmd_type   fl_cmd;

   // ---------------------------------------------------------------- handshake
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign exec      = (state_ff == ST_EXEC);

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- read side
   // stack tops in flops; an id beyond the configured stacks reads as empty
   assign req_exists = (32'(req_payload.stack_id) < NUM_STACKS);
   assign req_top    = req_exists ? top_ff[req_payload.stack_id[TW-1:0]] : NIL;
   assign cur_exists = (32'(sid_ff) < NUM_STACKS);
   assign cur_top    = cur_exists ? top_ff[sid_ff[TW-1:0]] : NIL;

   // push follows the free head, pop follows the stack top
   assign link_raddr_full = (req_payload.func == FUNC_PUSH) ? free_head : req_top;
   assign link_raddr      = link_raddr_full[AW-1:0];

   // ---------------------------------------------------------------- execute
   assign push_ok = exec && (op_ff == FUNC_PUSH) && cur_exists && !head_nil;
   assign pop_ok  = exec && (op_ff == FUNC_POP) && cur_exists && (cur_top != NIL);

   always_comb begin
      fl_cmd.alloc     = push_ok;
      fl_cmd.release_s = pop_ok;
      slot       = push_ok ? free_head : cur_top;
      link_we    = push_ok || pop_ok;
      link_wdata = push_ok ? cur_top : free_head;
      data_we    = push_ok;
      for (int i = 0; i < TOPS; i++) begin
         top_in[i] = top_ff[i];
      end
      if (push_ok) begin
         top_in[sid_ff[TW-1:0]] = free_head;
      end else if (pop_ok) begin
         top_in[sid_ff[TW-1:0]] = link_rdata;
      end
   end

   // response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec) begin
         rsp_valid_in        = 1'b1;
         rsp_in.popped_value = pop_ok ? data_rdata : '0;
         if (op_ff == FUNC_PUSH) begin
            rsp_in.status = push_ok ? STATUS_OK : STATUS_OVERFLOW;
         end else begin
            rsp_in.status = pop_ok ? STATUS_OK : STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TOPS; i++) begin
            top_ff[i] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < TOPS; i++) begin
            top_ff[i] <= top_in[i];
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff  <= req_payload.func;
         sid_ff <= req_payload.stack_id;
         val_ff <= req_payload.value;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------- storage
   msfl_free #(
      .SLOTS (SLOTS),
      .LW    (LW)
   ) u_free (
      .clock        (clock),
      .reset        (reset),
      .cmd          (fl_cmd),
      .link_rdata   (link_rdata),
      .release_slot (cur_top),
      .free_head    (free_head),
      .head_nil     (head_nil)
   );

   msfl_ram #(
      .WIDTH (LW),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (slot[AW-1:0]),
      .wdata (link_wdata),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   msfl_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOTS)
   ) u_data_ram (
      .clock (clock),
      .we    (data_we),
      .waddr (slot[AW-1:0]),
      .wdata (val_ff),
      .raddr (link_raddr),
      .rdata (data_rdata)
   );

   // ---------------------------------------------------------------- checks
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter execute");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid)
      else $error("execute cycle did not produce a response");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != STATUS_OK)) |-> (rsp_payload.popped_value == 0))
      else $error("failed operation returned a nonzero value");

   a_no_double_update: assert property (@(posedge clock) disable iff (reset)
      !(push_ok && pop_ok))
      else $error("push and pop committed together");

endmodule

[tb/sv/multi_stack_shared_free_list_test.sv]
// Self-checking testbench for multi_stack_shared_free_list: directed and random push/pop items,
// checked against an in-bench shadow of the stacks and free list.
// Depends on msfl_pkg and the multi_stack_shared_free_list RTL.
`timescale 1ns / 100ps

module multi_stack_shared_free_list_test;
   import msfl_pkg::*;

   localparam int SLOT_COUNT  = 256;
   localparam int STACK_COUNT = 8;
   localparam logic [8:0] NIL_LINK = 9'(SLOT_COUNT);
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   msfl_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   msfl_rsp_type rsp_payload;

   multi_stack_shared_free_list #(
      .SLOTS      (SLOT_COUNT),
      .NUM_STACKS (STACK_COUNT)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Shadow of the block: data slots, links, stack tops and free head.
   logic [DATA_W-1:0] shadow_data [SLOT_COUNT];
   logic [8:0]        shadow_link [SLOT_COUNT];
   logic [8:0]        shadow_top  [STACK_COUNT];
   logic [8:0]        shadow_free;

   msfl_rsp_type expected_rsps [$];
   msfl_rsp_type oldest_rsp;
   int           fail_count;
   int unsigned  cycle_count = 0;
   bit           idle_on;    // random gaps on both channels

   // Clock: 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Apply one operation to the shadow and return the item the block should send back.
   function automatic msfl_rsp_type predict_stack_op(input msfl_req_type item);
      msfl_rsp_type r;
      logic [8:0]   slot;
      r.popped_value = '0;
      r.status       = STATUS_OK;
      if (item.func == FUNC_PUSH) begin
         if (int'(item.stack_id) >= STACK_COUNT || shadow_free == NIL_LINK) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            // take the free head, chain it onto the stack
            slot                       = shadow_free;
            shadow_data[slot[7:0]]     = item.value;
            shadow_free                = shadow_link[slot[7:0]];
            shadow_link[slot[7:0]]     = shadow_top[item.stack_id];
            shadow_top[item.stack_id]  = slot;
         end
      end else begin
         if (int'(item.stack_id) >= STACK_COUNT || shadow_top[item.stack_id] == NIL_LINK) begin
            r.status = STATUS_EMPTY;
         end else begin
            // unlink the top, hand it back as the new free head
            slot                       = shadow_top[item.stack_id];
            r.popped_value             = shadow_data[slot[7:0]];
            shadow_top[item.stack_id]  = shadow_link[slot[7:0]];
            shadow_link[slot[7:0]]     = shadow_free;
            shadow_free                = slot;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Result checker: every accepted result item against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result item", DATA_W'(rsp_payload), '0);
         end else begin
            oldest_rsp = expected_rsps.pop_front();
            if (rsp_payload.popped_value !== oldest_rsp.popped_value)
               report_mismatch("popped_value", rsp_payload.popped_value,
                               oldest_rsp.popped_value);
            if (rsp_payload.status !== oldest_rsp.status)
               report_mismatch("status", DATA_W'(rsp_payload.status),
                               DATA_W'(oldest_rsp.status));
         end
      end
   end

   // Result-side stall: raised in random bursts while idling is on.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && !reset && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one item. Called at a falling edge; returns at the falling edge after acceptance.
   // Valid stays high into the next call unless a gap is taken, so it never drops and rises
   // in the same step.
   task automatic send_item(input msfl_req_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      expected_rsps.push_back(predict_stack_op(item));
      @(negedge clock);
   endtask

   // Stop sending and let all outstanding result items drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_op(input msfl_func_type op, input int sid, input logic [DATA_W-1:0] v);
      msfl_req_type item;
      item.func     = op;
      item.stack_id = SID_W'(sid);
      item.value    = v;
      send_item(item);
   endtask

   // Random item: push with the given odds, stack either random or the focused one.
   task automatic send_random(input int push_pct, input int focus_sid);
      int sid;
      sid = (focus_sid >= 0 && $urandom_range(0, 2) != 0) ? focus_sid
                                                          : $urandom_range(0, 7);
      send_op(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP, sid, pick_value());
   endtask

   task automatic apply_reset();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      idle_on     = 1'b0;
      fail_count  = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_data[i] = '0;
         shadow_link[i] = (i == SLOT_COUNT - 1) ? NIL_LINK : 9'(i + 1);
      end
      for (int i = 0; i < STACK_COUNT; i++) shadow_top[i] = NIL_LINK;
      shadow_free = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
   endtask

   // Pop on every stack right after reset: all empty.
   task automatic test_empty_pops();
      idle_on = 1'b1;
      for (int s = 0; s < STACK_COUNT; s++)
         send_op(FUNC_POP, s, (s % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000);
      wait_idle();
   endtask

   // Extreme values through the outer stacks, popped back in LIFO order.
   task automatic test_value_extremes();
      logic [DATA_W-1:0] vals [8];
      vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFE};
      for (int i = 0; i < 8; i++) send_op(FUNC_PUSH, (i % 2 == 0) ? 0 : 7, vals[i]);
      for (int i = 0; i < 8; i++) send_op(FUNC_POP, (i % 2 == 0) ? 7 : 0, $urandom);
      wait_idle();
   endtask

   // Fill the whole store, hit overflow, churn near full, then drain everything.
   task automatic test_full_store();
      int sid;
      idle_on = 1'b0;
      while (shadow_free != NIL_LINK) begin
         if (shadow_top[0] == NIL_LINK) idle_on = 1'b1; // set idling if stack 0 is empty
         send_op(FUNC_PUSH, $urandom_range(0, 7), pick_value());
      end
      idle_on = 1'b1;
      for (int s = 0; s < 4; s++) send_op(FUNC_PUSH, $urandom_range(0, 7), pick_value());
      // near-full churn: freed slots come straight back, with overflows in between
      repeat (40) send_random(60, -1);
      // drain: aim pops at stacks that still hold something
      while (shadow_free != NIL_LINK || shadow_top[0] != NIL_LINK ||
             shadow_top[1] != NIL_LINK || shadow_top[2] != NIL_LINK ||
             shadow_top[3] != NIL_LINK || shadow_top[4] != NIL_LINK ||
             shadow_top[5] != NIL_LINK || shadow_top[6] != NIL_LINK ||
             shadow_top[7] != NIL_LINK) begin
         sid = $urandom_range(0, 7);
         for (int k = 0; k < STACK_COUNT && shadow_top[sid] == NIL_LINK; k++)
            sid = (sid + 1) % STACK_COUNT;
         if (shadow_top[sid] == NIL_LINK) break;
         send_op(FUNC_POP, sid, $urandom);
      end
      // a few pops on the now-empty stacks
      for (int s = 0; s < 3; s++) send_op(FUNC_POP, $urandom_range(0, 7), $urandom);
      wait_idle();
   endtask

   // Mixed traffic with changing push odds and a focused stack; last stretch with no idling.
   task automatic test_random_mix();
      idle_on = 1'b1;
      repeat (20) send_random(75, -1);
      repeat (15) send_random(35, $urandom_range(0, 7));
      repeat (20) send_random(50, -1);
      idle_on = 1'b0;
      repeat (15) send_random(70, $urandom_range(0, 7));
      repeat (15) send_random(45, -1);
      wait_idle();
   endtask

   initial begin
      apply_reset();
      test_empty_pops();
      test_value_extremes();
      test_full_store();
      test_random_mix();
      idle_on = 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/msfl_pkg.sv
hw/rtl/msfl_ram.sv
hw/rtl/msfl_free.sv
hw/rtl/multi_stack_shared_free_list.sv
tb/sv/multi_stack_shared_free_list_test.sv
